// File: rtl/mcw_pkg.sv
package mcw_pkg;

  // Window store depth and derived widths
  localparam int MaxText    = 4096;
  localparam int TextAw     = $clog2(MaxText);
  localparam int IdxW       = TextAw + 1;
  localparam int NeedW      = 14;
  localparam int NeedMax    = 8191;
  localparam int DistW      = 9;
  localparam int NumValues  = 256;
  localparam int ChW        = 8;
  localparam int EntryW     = NeedW + 1;

  // Command queue between front and back
  localparam int QueueDepth = 2;
  localparam int QPtrW      = $clog2(QueueDepth);
  localparam int QCntW      = $clog2(QueueDepth + 1);

  typedef logic [IdxW-1:0]         idx_t;
  typedef logic [TextAw-1:0]       addr_t;
  typedef logic signed [NeedW-1:0] cnt_t;
  typedef logic [DistW-1:0]        dist_t;
  typedef logic [ChW-1:0]          ch_t;
  typedef logic [QPtrW-1:0]        qptr_t;
  typedef logic [QCntW-1:0]        qcnt_t;

  typedef enum logic [1:0] {
    KIND_PATTERN,
    KIND_TEXT,
    KIND_TEXT_LAST
  } mcw_kind_e;

  typedef struct packed {
    mcw_kind_e kind;
    ch_t       ch;
  } mcw_cmd_t;

  typedef struct packed {
    logic  found;
    addr_t win_start;
    idx_t  win_length;
    logic  overflow;
  } mcw_result_t;

endpackage

// File: rtl/minimum_covering_window.sv
// Channel  | Direction | Handshake                     | Payload
// ---------+-----------+-------------------------------+----------------------------------
// input    | in        | push, full (take: push & !full)| op_i, ch_i, last_i
// result   | out       | empty, pop (take: pop & !empty)| found_o, win_start_o,
//          |           |                               | win_length_o, overflow_o
//
// A pattern byte passes the idle and pattern-write states of the back end, a stored
// text byte the idle and text-update states plus the left-text and left-need states
// for every step of the left edge, and a dropped text byte or an ignored pattern byte
// only the idle state; the need table's registered read, then write back, sets these.
// The result then waits in the result state while the output item is not popped.
// Reset clears all control state at once; valid bits stand for the need table.
// A two-item queue parts the input side from the back end.
module minimum_covering_window (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input queue side
  input  logic        push,
  output logic        full,
  input  logic        op_i,
  input  logic [7:0]  ch_i,
  input  logic        last_i,
  // Result queue side
  output logic        empty,
  input  logic        pop,
  output logic        found_o,
  output logic [11:0] win_start_o,
  output logic [12:0] win_length_o,
  output logic        overflow_o
);

  mcw_pkg::mcw_cmd_t    cmd;
  logic                 cmd_valid;
  logic                 cmd_pop;
  mcw_pkg::mcw_result_t res;
  logic                 res_valid;
  logic                 res_ready;

  // Output register: holds the finished item until popped
  mcw_pkg::mcw_result_t out_q;
  logic                 out_valid_q, out_valid_d;
  logic                 out_take;

  // Accept and classify items, queue them for the back end
  mcw_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .op_i       (op_i),
    .ch_i       (ch_i),
    .last_i     (last_i),
    .cmd_valid_o(cmd_valid),
    .cmd_o      (cmd),
    .cmd_pop_i  (cmd_pop)
  );

  // Slide the window over the text store and track the best window
  mcw_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_valid_i(cmd_valid),
    .cmd_i      (cmd),
    .cmd_pop_o  (cmd_pop),
    .res_ready_i(res_ready),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  assign out_take  = pop && out_valid_q;
  // Refill in the same cycle the held item leaves
  assign res_ready = !out_valid_q || out_take;

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_take) begin
      out_valid_d = 1'b0;
    end
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign empty        = !out_valid_q;
  assign found_o      = out_q.found;
  assign win_start_o  = out_q.win_start;
  assign win_length_o = out_q.win_length;
  assign overflow_o   = out_q.overflow;

endmodule

// File: rtl/mcw_ram.sv
module mcw_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/mcw_front.sv
module mcw_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  output logic              full,
  input  logic              op_i,
  input  logic [7:0]        ch_i,
  input  logic              last_i,
  output logic              cmd_valid_o,
  output mcw_pkg::mcw_cmd_t cmd_o,
  input  logic              cmd_pop_i
);

  mcw_pkg::mcw_cmd_t fifo_q [mcw_pkg::QueueDepth];
  mcw_pkg::qptr_t    wptr_q, wptr_d;
  mcw_pkg::qptr_t    rptr_q, rptr_d;
  mcw_pkg::qcnt_t    cnt_q, cnt_d;
  mcw_pkg::mcw_cmd_t in_cmd;
  logic              wr_en;
  logic              rd_en;

  // Classify: a last flag on a pattern byte means nothing
  always_comb begin
    in_cmd.ch = ch_i;
    priority if (!op_i) begin
      in_cmd.kind = mcw_pkg::KIND_PATTERN;
    end else if (last_i) begin
      in_cmd.kind = mcw_pkg::KIND_TEXT_LAST;
    end else begin
      in_cmd.kind = mcw_pkg::KIND_TEXT;
    end
  end

  assign full        = (cnt_q == mcw_pkg::qcnt_t'(mcw_pkg::QueueDepth));
  assign wr_en       = push && !full;
  assign cmd_valid_o = (cnt_q != '0);
  assign rd_en       = cmd_pop_i && cmd_valid_o;
  assign cmd_o       = fifo_q[rptr_q];

  always_comb begin
    wptr_d = wr_en ? wptr_q + mcw_pkg::qptr_t'(1) : wptr_q;
    rptr_d = rd_en ? rptr_q + mcw_pkg::qptr_t'(1) : rptr_q;
    cnt_d  = cnt_q + mcw_pkg::qcnt_t'(wr_en) - mcw_pkg::qcnt_t'(rd_en);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      fifo_q[wptr_q] <= in_cmd;
    end
  end

endmodule

// File: rtl/mcw_back.sv
module mcw_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cmd_valid_i,
  input  mcw_pkg::mcw_cmd_t    cmd_i,
  output logic                 cmd_pop_o,
  input  logic                 res_ready_i,
  output logic                 res_valid_o,
  output mcw_pkg::mcw_result_t res_o
);

  localparam logic [2:0] StIdle     = 3'd0;
  localparam logic [2:0] StPatWr    = 3'd1;
  localparam logic [2:0] StTxtUpd   = 3'd2;
  localparam logic [2:0] StLeftTxt  = 3'd3;
  localparam logic [2:0] StLeftNeed = 3'd4;
  localparam logic [2:0] StResult   = 3'd5;

  logic [2:0]                      state_q, state_d;
  mcw_pkg::ch_t                    naddr_q, naddr_d;
  logic                            last_q, last_d;
  logic [mcw_pkg::NumValues-1:0]   valid_q, valid_d;
  mcw_pkg::dist_t                  distinct_q, distinct_d;
  mcw_pkg::dist_t                  covered_q, covered_d;
  mcw_pkg::idx_t                   left_q, left_d;
  mcw_pkg::idx_t                   right_q, right_d;
  mcw_pkg::addr_t                  best_start_q, best_start_d;
  mcw_pkg::idx_t                   best_len_q, best_len_d;
  logic                            best_valid_q, best_valid_d;
  logic                            ovf_q, ovf_d;

  logic                            n_we;
  mcw_pkg::ch_t                    n_raddr;
  logic [mcw_pkg::EntryW-1:0]      n_wdata;
  logic [mcw_pkg::EntryW-1:0]      n_rdata;
  logic                            t_we;
  mcw_pkg::addr_t                  t_raddr;
  mcw_pkg::ch_t                    t_rdata;

  logic [mcw_pkg::EntryW-1:0]      need_entry;
  logic                            ent_inpat;
  mcw_pkg::cnt_t                   ent_cnt;

  // Need table: {in_pattern, need_count}, unwritten entries read as zero
  mcw_ram #(
    .Width(mcw_pkg::EntryW),
    .Depth(mcw_pkg::NumValues)
  ) u_need_ram (
    .clk_i  (clk_i),
    .we_i   (n_we),
    .waddr_i(naddr_q),
    .wdata_i(n_wdata),
    .raddr_i(n_raddr),
    .rdata_o(n_rdata)
  );

  mcw_ram #(
    .Width(mcw_pkg::ChW),
    .Depth(mcw_pkg::MaxText)
  ) u_text_ram (
    .clk_i  (clk_i),
    .we_i   (t_we),
    .waddr_i(right_q[mcw_pkg::TextAw-1:0]),
    .wdata_i(cmd_i.ch),
    .raddr_i(t_raddr),
    .rdata_o(t_rdata)
  );

  assign need_entry = valid_q[naddr_q] ? n_rdata : '0;
  assign ent_inpat  = need_entry[mcw_pkg::EntryW-1];
  assign ent_cnt    = mcw_pkg::cnt_t'(need_entry[mcw_pkg::NeedW-1:0]);

  always_comb begin
    mcw_pkg::cnt_t  cnt_n;
    mcw_pkg::dist_t cov_n;
    mcw_pkg::idx_t  left_n;
    mcw_pkg::idx_t  len;
    logic           loop_go;

    state_d      = state_q;
    naddr_d      = naddr_q;
    last_d       = last_q;
    valid_d      = valid_q;
    distinct_d   = distinct_q;
    covered_d    = covered_q;
    left_d       = left_q;
    right_d      = right_q;
    best_start_d = best_start_q;
    best_len_d   = best_len_q;
    best_valid_d = best_valid_q;
    ovf_d        = ovf_q;

    cmd_pop_o    = 1'b0;
    res_valid_o  = 1'b0;
    n_we         = 1'b0;
    n_raddr      = cmd_i.ch;
    n_wdata      = '0;
    t_we         = 1'b0;
    t_raddr      = left_q[mcw_pkg::TextAw-1:0];

    cnt_n   = ent_cnt;
    cov_n   = covered_q;
    left_n  = left_q;
    len     = right_q - left_q;
    loop_go = 1'b0;

    unique case (state_q)
      StIdle: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          naddr_d   = cmd_i.ch;
          last_d    = (cmd_i.kind == mcw_pkg::KIND_TEXT_LAST);
          unique case (cmd_i.kind)
            mcw_pkg::KIND_PATTERN: begin
              if ((right_q == '0) && !ovf_q) begin
                state_d = StPatWr;
              end
            end
            mcw_pkg::KIND_TEXT, mcw_pkg::KIND_TEXT_LAST: begin
              if (right_q == mcw_pkg::idx_t'(mcw_pkg::MaxText)) begin
                // Store full: drop the byte, flag it
                ovf_d = 1'b1;
                if (cmd_i.kind == mcw_pkg::KIND_TEXT_LAST) begin
                  state_d = StResult;
                end
              end else begin
                t_we    = 1'b1;
                right_d = right_q + mcw_pkg::idx_t'(1);
                state_d = StTxtUpd;
              end
            end
            default: begin
            end
          endcase
        end
      end

      StPatWr: begin
        if (!ent_inpat) begin
          distinct_d = distinct_q + mcw_pkg::dist_t'(1);
        end
        if (ent_cnt < mcw_pkg::NeedMax) begin
          cnt_n = ent_cnt + mcw_pkg::cnt_t'(1);
        end
        n_we             = 1'b1;
        n_wdata          = {1'b1, cnt_n};
        valid_d[naddr_q] = 1'b1;
        state_d          = StIdle;
      end

      StTxtUpd: begin
        if (ent_inpat) begin
          cnt_n   = ent_cnt - mcw_pkg::cnt_t'(1);
          n_we    = 1'b1;
          n_wdata = {1'b1, cnt_n};
          if (cnt_n == '0) begin
            cov_n = covered_q + mcw_pkg::dist_t'(1);
          end
        end
        covered_d = cov_n;
        loop_go   = (distinct_q != '0) && (cov_n == distinct_q) && (left_q < right_q);
        if (loop_go) begin
          t_raddr = left_q[mcw_pkg::TextAw-1:0];
          state_d = StLeftTxt;
        end else begin
          state_d = last_q ? StResult : StIdle;
        end
      end

      StLeftTxt: begin
        // Record the window; strict compare keeps the earliest on ties
        if (!best_valid_q || (len < best_len_q)) begin
          best_valid_d = 1'b1;
          best_start_d = left_q[mcw_pkg::TextAw-1:0];
          best_len_d   = len;
        end
        n_raddr = t_rdata;
        naddr_d = t_rdata;
        state_d = StLeftNeed;
      end

      StLeftNeed: begin
        if (ent_inpat) begin
          if (ent_cnt == '0) begin
            cov_n = covered_q - mcw_pkg::dist_t'(1);
          end
          cnt_n   = ent_cnt + mcw_pkg::cnt_t'(1);
          n_we    = 1'b1;
          n_wdata = {1'b1, cnt_n};
        end
        left_n    = left_q + mcw_pkg::idx_t'(1);
        covered_d = cov_n;
        left_d    = left_n;
        loop_go   = (distinct_q != '0) && (cov_n == distinct_q) && (left_n < right_q);
        if (loop_go) begin
          t_raddr = left_n[mcw_pkg::TextAw-1:0];
          state_d = StLeftTxt;
        end else begin
          state_d = last_q ? StResult : StIdle;
        end
      end

      StResult: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          valid_d      = '0;
          distinct_d   = '0;
          covered_d    = '0;
          left_d       = '0;
          right_d      = '0;
          best_start_d = '0;
          best_len_d   = '1;
          best_valid_d = 1'b0;
          ovf_d        = 1'b0;
          state_d      = StIdle;
        end
      end

      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_comb begin
    res_o.found      = best_valid_q;
    res_o.win_start  = best_valid_q ? best_start_q : '0;
    res_o.win_length = best_valid_q ? best_len_q : '0;
    res_o.overflow   = ovf_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      last_q       <= 1'b0;
      valid_q      <= '0;
      distinct_q   <= '0;
      covered_q    <= '0;
      left_q       <= '0;
      right_q      <= '0;
      best_start_q <= '0;
      best_len_q   <= '1;
      best_valid_q <= 1'b0;
      ovf_q        <= 1'b0;
    end else begin
      state_q      <= state_d;
      last_q       <= last_d;
      valid_q      <= valid_d;
      distinct_q   <= distinct_d;
      covered_q    <= covered_d;
      left_q       <= left_d;
      right_q      <= right_d;
      best_start_q <= best_start_d;
      best_len_q   <= best_len_d;
      best_valid_q <= best_valid_d;
      ovf_q        <= ovf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    naddr_q <= naddr_d;
  end

endmodule

// File: rtl/mcw_checker.sv
module mcw_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        empty,
  input logic        pop,
  input logic        found_o,
  input logic [11:0] win_start_o,
  input logic [12:0] win_length_o,
  input logic        overflow_o
);

  // No window: start and length read zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !found_o) |-> ((win_start_o == '0) && (win_length_o == '0)))
    else $error("result without window has nonzero start or length");

  // A found window is never empty
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && found_o) |-> (win_length_o != '0))
    else $error("found window has zero length");

  // A found window lies inside the window store
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && found_o) |->
      (({1'b0, win_start_o} + {1'b0, win_length_o}) <= 14'(mcw_pkg::MaxText)))
    else $error("found window runs past the window store");

  // A stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(found_o) && $stable(win_start_o) &&
                          $stable(win_length_o) && $stable(overflow_o)))
    else $error("stalled result changed or vanished");

endmodule

bind minimum_covering_window mcw_checker u_mcw_checker (.*);
